### rtl/core/mstt_pkg.sv
// ----------------------------------------------------------------------------
// mstt_pkg
// Shared types, codes and sizes for the multiplexed timeout table.
// ----------------------------------------------------------------------------
package mstt_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int TIME_W        = 64;
    localparam int DUR_W         = 32;

    // opcodes
    localparam logic [2:0] OP_ALLOC   = 3'd0;
    localparam logic [2:0] OP_REARM   = 3'd1;
    localparam logic [2:0] OP_RELEASE = 3'd2;
    localparam logic [2:0] OP_REL_ALL = 3'd3;
    localparam logic [2:0] OP_QUERY   = 3'd4;
    localparam logic [2:0] OP_TICK    = 3'd5;

    // slot kinds
    localparam logic [1:0] KIND_INVALID  = 2'd0;
    localparam logic [1:0] KIND_ONESHOT  = 2'd1;
    localparam logic [1:0] KIND_PERIODIC = 2'd2;

    // status codes
    localparam logic STAT_OK  = 1'b0;
    localparam logic STAT_ERR = 1'b1;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [3:0]  slot;
        logic [1:0]  kind;
        logic [31:0] duration;
    } cmd_beat_t;

    typedef struct packed {
        logic        status;
        logic [3:0]  slot_out;
        logic        passed;
        logic [1:0]  slot_kind;
        logic [4:0]  slots_in_use_bound;
        logic        next_valid;
        logic [31:0] next_ticks;
    } rsp_beat_t;

endpackage

### rtl/core/mstt_adder.sv
// ----------------------------------------------------------------------------
// mstt_adder
// Shared 64-bit add/subtract unit with carry out.
// ----------------------------------------------------------------------------
module mstt_adder (
    input  logic [mstt_pkg::TIME_W-1:0] a,
    input  logic [mstt_pkg::TIME_W-1:0] b,
    input  logic                        sub,
    output logic [mstt_pkg::TIME_W-1:0] sum,
    output logic                        carry
);
    import mstt_pkg::*;

    logic [TIME_W-1:0] b_eff;

    // subtract as a plus inverted b plus one
    assign b_eff = sub ? ~b : b;
    assign {carry, sum} = {1'b0, a} + {1'b0, b_eff} + {{TIME_W{1'b0}}, sub};

endmodule

### rtl/core/multi_slot_timeout_table.sv
// A command passes through the prep state, then a slot scan that visits one
// slot per cycle through the shared 64-bit adder, then the done state that
// loads the response register; cmd_stall holds the next command until idle.
// The response register lets a new command enter while a response waits.
// Reset clears all slot flags, kinds, the high-water mark and the time base.
// ----------------------------------------------------------------------------
// multi_slot_timeout_table
// Timeout slot table on one tick base with a sequenced per-slot scan.
// ----------------------------------------------------------------------------
module multi_slot_timeout_table #(
    parameter int NUM_SLOTS = mstt_pkg::NUM_SLOTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  mstt_pkg::cmd_beat_t cmd,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output mstt_pkg::rsp_beat_t rsp
);
    import mstt_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int HW_W  = $clog2(NUM_SLOTS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]        state_reg, state_next;
    cmd_beat_t         cmd_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [HW_W-1:0]   hw_reg;
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] arm_reg;
    logic              in_range_reg;
    logic              alloc_ok_reg;
    logic              found_reg;

    // slot state
    logic [NUM_SLOTS-1:0] used_reg, armed_reg, passed_reg;
    logic [1:0]           kind_reg [NUM_SLOTS];
    logic [DUR_W-1:0]     dur_mem [NUM_SLOTS];
    logic [TIME_W-1:0]    dl_mem [NUM_SLOTS];

    // result accumulators
    logic        st_reg;
    logic [3:0]  so_reg;
    logic        ps_reg;
    logic [1:0]  ko_reg;
    logic        bv_reg;
    logic [31:0] best_reg;

    logic      rsp_valid_reg;
    rsp_beat_t rsp_reg;

    // adder connections
    logic [TIME_W-1:0] add_a, add_b, add_sum;
    logic              add_sub, add_carry;

    mstt_adder u_adder (
        .a     (add_a),
        .b     (add_b),
        .sub   (add_sub),
        .sum   (add_sum),
        .carry (add_carry)
    );

    // scan step signals
    logic              at_slot, do_clear, do_arm, do_alloc;
    logic              u_n, a_n, p_n, pend_n, le;
    logic [1:0]        k_n;
    logic [TIME_W-1:0] dl_n;
    logic [31:0]       sat;
    logic [IDX_W-1:0]  slot_idx;
    logic [DUR_W-1:0]  dur_sel;

    assign slot_idx = IDX_W'(cmd_reg.slot);
    assign at_slot  = in_range_reg && (32'(cmd_reg.slot) == 32'(idx_reg));

    // prep operand for the arm deadline: the stored duration on rearm, else the command's
    always_comb
    begin
        dur_sel = (cmd_reg.opcode == OP_REARM) ? dur_mem[slot_idx] : cmd_reg.duration;
    end

    // per-slot update of the addressed or scanned slot
    always_comb
    begin
        do_clear = 1'b0;
        do_arm   = 1'b0;
        do_alloc = 1'b0;
        unique case (cmd_reg.opcode)
            OP_ALLOC:
                do_alloc = alloc_ok_reg && !found_reg && !used_reg[idx_reg];
            OP_REARM:
            begin
                do_arm   = at_slot && (kind_reg[idx_reg] == KIND_PERIODIC);
                do_clear = at_slot && (kind_reg[idx_reg] != KIND_PERIODIC);
            end
            OP_RELEASE:
                do_clear = at_slot;
            OP_REL_ALL:
                do_clear = 32'(idx_reg) < 32'(hw_reg);
            default:
                do_clear = 1'b0;
        endcase

        u_n  = used_reg[idx_reg];
        a_n  = armed_reg[idx_reg];
        k_n  = kind_reg[idx_reg];
        dl_n = dl_mem[idx_reg];
        if (do_alloc || do_arm)
        begin
            u_n  = 1'b1;
            a_n  = 1'b1;
            dl_n = arm_reg;
            if (do_alloc)
                k_n = cmd_reg.kind;
        end
        else if (do_clear)
        begin
            u_n = 1'b0;
            a_n = 1'b0;
            k_n = KIND_INVALID;
        end
    end

    // adder operand selection
    always_comb
    begin
        if (state_reg == S_PREP)
        begin
            add_a   = now_reg;
            add_b   = (cmd_reg.opcode == OP_TICK) ? TIME_W'(1) : TIME_W'(dur_sel);
            add_sub = 1'b0;
        end
        else
        begin
            add_a   = dl_n;
            add_b   = now_reg;
            add_sub = 1'b1;
        end
    end

    // expiry and distance of the scanned slot
    always_comb
    begin
        le = !add_carry || (add_sum == '0);
        p_n = passed_reg[idx_reg];
        if (do_alloc || do_arm || do_clear)
            p_n = 1'b0;
        else if (cmd_reg.opcode == OP_TICK && u_n && a_n && le)
            p_n = 1'b1;
        pend_n = u_n && a_n && !p_n;
        if (!add_carry)
            sat = '0;
        else if (|add_sum[TIME_W-1:32])
            sat = 32'hFFFF_FFFF;
        else
            sat = add_sum[31:0];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (cmd_valid)
                    state_next = S_PREP;
            S_PREP:
                state_next = S_SCAN;
            S_SCAN:
                if (idx_reg == IDX_W'(NUM_SLOTS - 1))
                    state_next = S_DONE;
            S_DONE:
                if (!rsp_valid_reg || !rsp_stall)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    assign cmd_stall = (state_reg != S_IDLE);

    // control and slot flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            hw_reg        <= '0;
            now_reg       <= '0;
            found_reg     <= 1'b0;
            used_reg      <= '0;
            armed_reg     <= '0;
            passed_reg    <= '0;
            rsp_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_SLOTS; k++)
                kind_reg[k] <= KIND_INVALID;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_PREP)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
                if (cmd_reg.opcode == OP_TICK)
                    now_reg <= add_sum;
            end
            if (state_reg == S_SCAN)
            begin
                idx_reg              <= idx_reg + IDX_W'(1);
                used_reg[idx_reg]    <= u_n;
                armed_reg[idx_reg]   <= a_n;
                passed_reg[idx_reg]  <= p_n;
                kind_reg[idx_reg]    <= k_n;
                if (do_alloc)
                begin
                    found_reg <= 1'b1;
                    if (32'(hw_reg) < 32'(idx_reg) + 32'd1)
                        hw_reg <= HW_W'(32'(idx_reg) + 32'd1);
                end
                if (idx_reg == IDX_W'(NUM_SLOTS - 1) && cmd_reg.opcode == OP_REL_ALL)
                    hw_reg <= '0;
            end
            // response register
            if (state_reg == S_DONE && (!rsp_valid_reg || !rsp_stall))
                rsp_valid_reg <= 1'b1;
            else if (rsp_valid_reg && !rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && cmd_valid)
            cmd_reg <= cmd;
        if (state_reg == S_PREP)
        begin
            arm_reg      <= add_sum;
            in_range_reg <= (32'(cmd_reg.slot) < 32'(hw_reg))
                            && (32'(cmd_reg.slot) < NUM_SLOTS);
            alloc_ok_reg <= (cmd_reg.duration != '0)
                            && (cmd_reg.kind == KIND_ONESHOT
                                || cmd_reg.kind == KIND_PERIODIC);
            st_reg   <= (cmd_reg.opcode == OP_TICK || cmd_reg.opcode == OP_REL_ALL)
                        ? STAT_OK : STAT_ERR;
            so_reg   <= cmd_reg.slot;
            ps_reg   <= 1'b0;
            ko_reg   <= KIND_INVALID;
            bv_reg   <= 1'b0;
            best_reg <= '0;
        end
        if (state_reg == S_SCAN)
        begin
            dl_mem[idx_reg] <= dl_n;
            if (do_alloc)
                dur_mem[idx_reg] <= cmd_reg.duration;
            else if (do_clear)
                dur_mem[idx_reg] <= '0;
            // result of the addressed slot
            if (do_alloc)
            begin
                st_reg <= STAT_OK;
                so_reg <= 4'(idx_reg);
                ko_reg <= cmd_reg.kind;
            end
            else if (do_arm)
            begin
                st_reg <= STAT_OK;
                ko_reg <= KIND_PERIODIC;
            end
            else if (do_clear && cmd_reg.opcode != OP_REL_ALL)
            begin
                st_reg <= (used_reg[idx_reg] && armed_reg[idx_reg]) ? STAT_OK : STAT_ERR;
                ps_reg <= used_reg[idx_reg] && armed_reg[idx_reg] && passed_reg[idx_reg];
            end
            else if (cmd_reg.opcode == OP_QUERY && at_slot)
            begin
                ko_reg <= kind_reg[idx_reg];
                if (kind_reg[idx_reg] != KIND_INVALID && used_reg[idx_reg]
                    && armed_reg[idx_reg])
                begin
                    st_reg <= STAT_OK;
                    ps_reg <= passed_reg[idx_reg];
                end
            end
            // nearest pending deadline
            if (pend_n && (!bv_reg || sat < best_reg))
                best_reg <= sat;
            if (pend_n)
                bv_reg <= 1'b1;
        end
        if (state_reg == S_DONE && (!rsp_valid_reg || !rsp_stall))
        begin
            rsp_reg.status             <= st_reg;
            rsp_reg.slot_out           <= so_reg;
            rsp_reg.passed             <= ps_reg;
            rsp_reg.slot_kind          <= ko_reg;
            rsp_reg.slots_in_use_bound <= 5'(hw_reg);
            rsp_reg.next_valid         <= bv_reg;
            rsp_reg.next_ticks         <= best_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives allocate, rearm, release, release-all, query and tick beats into the
// timeout table under several idling and back-pressure phases. A scoreboard
// keeps its own copy of the slot table and checks every response field.
// ----------------------------------------------------------------------------
module testbench;
    import mstt_pkg::*;

    localparam int NSLOT      = NUM_SLOTS_DEF;
    localparam int IDLE_LIMIT = 20000;
    localparam int RAND_ITEMS = 420;

    // slot table shadow and expected response store
    class timeout_scoreboard;
        bit          used_q [NSLOT];
        bit          armed_q [NSLOT];
        bit          fired_q [NSLOT];
        logic [1:0]  kind_q [NSLOT];
        logic [31:0] dur_q [NSLOT];
        logic [63:0] due_q [NSLOT];
        logic [4:0]  high_mark;
        logic [63:0] now_q;
        rsp_beat_t   pending_rsp [$];
        int          mismatches;
        int          checked;
        int          fired_seen;
        int          err_seen;

        // shadow starts out as the block does after reset
        function new();
            for (int i = 0; i < NSLOT; i++)
            begin
                used_q[i] = 0;
                armed_q[i] = 0;
                fired_q[i] = 0;
                kind_q[i] = KIND_INVALID;
                dur_q[i] = '0;
                due_q[i] = '0;
            end
            high_mark = '0;
            now_q = '0;
            mismatches = 0;
            checked = 0;
            fired_seen = 0;
            err_seen = 0;
        endfunction

        function void clear_slot(int i, output logic ok, output logic was_fired);
            ok = used_q[i] && armed_q[i];
            was_fired = ok ? fired_q[i] : 1'b0;
            used_q[i] = 0;
            armed_q[i] = 0;
            fired_q[i] = 0;
            kind_q[i] = KIND_INVALID;
            dur_q[i] = '0;
        endfunction

        function void arm(int i);
            fired_q[i] = 0;
            armed_q[i] = 1;
            due_q[i] = now_q + 64'(dur_q[i]);
        endfunction

        // work out the response to one accepted command beat
        function void note_cmd(cmd_beat_t c);
            rsp_beat_t r;
            logic      ok, fired, found, in_range;
            logic [63:0] d, best;
            int        i;
            r = '0;
            r.status = STAT_ERR;
            r.slot_out = c.slot;
            r.slot_kind = KIND_INVALID;
            in_range = 5'(c.slot) < high_mark;
            case (c.opcode)
                OP_ALLOC:
                begin
                    if (c.duration != 0 && (c.kind == KIND_ONESHOT || c.kind == KIND_PERIODIC))
                    begin
                        found = 0;
                        for (i = 0; i < NSLOT && !found; i++)
                        begin
                            if (!used_q[i])
                            begin
                                found = 1;
                                used_q[i] = 1;
                                kind_q[i] = c.kind;
                                dur_q[i] = c.duration;
                                arm(i);
                                if (high_mark < 5'(i + 1))
                                    high_mark = 5'(i + 1);
                                r.status = STAT_OK;
                                r.slot_out = 4'(i);
                                r.slot_kind = c.kind;
                            end
                        end
                    end
                end
                OP_REARM, OP_RELEASE:
                begin
                    if (in_range)
                    begin
                        if (c.opcode == OP_REARM && kind_q[c.slot] == KIND_PERIODIC)
                        begin
                            used_q[c.slot] = 1;
                            arm(c.slot);
                            r.status = STAT_OK;
                            r.slot_kind = KIND_PERIODIC;
                        end
                        else
                        begin
                            clear_slot(c.slot, ok, fired);
                            r.status = ok ? STAT_OK : STAT_ERR;
                            r.passed = fired;
                        end
                    end
                end
                OP_REL_ALL:
                begin
                    for (i = 0; i < NSLOT; i++)
                        if (5'(i) < high_mark)
                            clear_slot(i, ok, fired);
                    high_mark = '0;
                    r.status = STAT_OK;
                end
                OP_QUERY:
                begin
                    if (in_range)
                    begin
                        r.slot_kind = kind_q[c.slot];
                        if (r.slot_kind != KIND_INVALID && used_q[c.slot] && armed_q[c.slot])
                        begin
                            r.status = STAT_OK;
                            r.passed = fired_q[c.slot];
                        end
                    end
                end
                OP_TICK:
                begin
                    now_q = now_q + 1;
                    for (i = 0; i < NSLOT; i++)
                        if (used_q[i] && armed_q[i] && !fired_q[i] && due_q[i] <= now_q)
                            fired_q[i] = 1;
                    r.status = STAT_OK;
                end
                default: ;
            endcase
            // nearest pending deadline, saturated to 32 bits
            best = '0;
            found = 0;
            for (i = 0; i < NSLOT; i++)
            begin
                if (used_q[i] && armed_q[i] && !fired_q[i])
                begin
                    d = due_q[i] >= now_q ? due_q[i] - now_q : 64'd0;
                    if (!found || d < best)
                        best = d;
                    found = 1;
                end
            end
            r.slots_in_use_bound = high_mark;
            r.next_valid = found;
            r.next_ticks = best > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : best[31:0];
            pending_rsp.push_back(r);
        endfunction

        function void field(string name, logic [31:0] e, logic [31:0] a);
            if (e !== a)
            begin
                mismatches++;
                $display("%0t mismatch %s: expected %0h actual %0h", $time, name, e, a);
            end
        endfunction

        // compare one response beat with the oldest expectation
        function void check_rsp(rsp_beat_t a);
            rsp_beat_t e;
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                $display("%0t unexpected response: expected none actual %h", $time, a);
                return;
            end
            e = pending_rsp.pop_front();
            checked++;
            if (e.passed)
                fired_seen++;
            if (e.status == STAT_ERR)
                err_seen++;
            field("status", e.status, a.status);
            field("slot_out", e.slot_out, a.slot_out);
            field("passed", e.passed, a.passed);
            field("slot_kind", e.slot_kind, a.slot_kind);
            field("slots_in_use_bound", e.slots_in_use_bound, a.slots_in_use_bound);
            field("next_valid", e.next_valid, a.next_valid);
            field("next_ticks", e.next_ticks, a.next_ticks);
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    cmd_beat_t cmd = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_beat_t rsp;

    timeout_scoreboard sb = new();
    bit sender_idles = 0;
    bit receiver_stalls = 0;
    bit hold_request = 0;
    int idle_cycles = 0;
    int cmds_sent = 0;

    multi_slot_timeout_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // response side: random stall, long hold-off on request, check each beat
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 0;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= receiver_stalls ? ($urandom_range(99) < 88) : 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rsp_valid && !rsp_stall)
            sb.check_rsp(rsp);
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t timeout with %0d responses outstanding", $time,
                     sb.pending_rsp.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // offer one command beat, entered and left at a falling edge
    task automatic send(cmd_beat_t c);
        while (sender_idles && $urandom_range(99) < 88)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        do
            @(posedge clk);
        while (cmd_stall);
        sb.note_cmd(c);
        cmds_sent++;
        @(negedge clk);
    endtask

    function automatic cmd_beat_t mk(logic [2:0] op, logic [3:0] s, logic [1:0] k,
                                     logic [31:0] d);
        cmd_beat_t c;
        c.opcode = op;
        c.slot = s;
        c.kind = k;
        c.duration = d;
        return c;
    endfunction

    // random command, mostly aimed at live slots with short timeouts
    function automatic cmd_beat_t random_cmd();
        cmd_beat_t c;
        int        p;
        c = cmd_beat_t'($bits(cmd_beat_t)'({$urandom, $urandom}));
        p = $urandom_range(99);
        if (p < 28)       c.opcode = OP_ALLOC;
        else if (p < 58)  c.opcode = OP_TICK;
        else if (p < 72)  c.opcode = OP_QUERY;
        else if (p < 83)  c.opcode = OP_REARM;
        else if (p < 95)  c.opcode = OP_RELEASE;
        else if (p < 97)  c.opcode = OP_REL_ALL;
        else              c.opcode = 3'($urandom_range(6, 7));
        if ($urandom_range(99) < 75 && sb.high_mark != 0)
            c.slot = 4'($urandom_range(sb.high_mark - 1));
        if ($urandom_range(99) < 94)
            c.kind = $urandom_range(1) ? KIND_PERIODIC : KIND_ONESHOT;
        p = $urandom_range(99);
        if (p < 75)
            c.duration = $urandom_range(1, 12);
        else if (p < 82)
            c.duration = '0;
        return c;
    endfunction

    task automatic wait_drained();
        while (sb.pending_rsp.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int ph;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: rejects, both kinds, expiry, rearm, release, odd opcodes
        send(mk(OP_QUERY, 4'd0, KIND_ONESHOT, 32'd5));
        send(mk(OP_ALLOC, 4'd3, KIND_ONESHOT, 32'd0));
        send(mk(OP_ALLOC, 4'd3, KIND_INVALID, 32'd4));
        send(mk(OP_ALLOC, 4'd3, 2'd3, 32'd4));
        send(mk(OP_ALLOC, 4'd0, KIND_ONESHOT, 32'd1));
        send(mk(OP_ALLOC, 4'd0, KIND_PERIODIC, 32'd2));
        send(mk(OP_ALLOC, 4'd15, KIND_PERIODIC, 32'hFFFF_FFFF));
        send(mk(OP_TICK, 4'd0, KIND_INVALID, 32'd0));
        send(mk(OP_QUERY, 4'd0, KIND_INVALID, 32'd0));
        send(mk(OP_TICK, 4'd15, 2'd3, 32'hFFFF_FFFF));
        send(mk(OP_QUERY, 4'd1, KIND_INVALID, 32'd0));
        send(mk(OP_REARM, 4'd1, KIND_INVALID, 32'd0));
        send(mk(OP_REARM, 4'd0, KIND_INVALID, 32'd0));
        send(mk(OP_RELEASE, 4'd2, KIND_INVALID, 32'd0));
        send(mk(OP_RELEASE, 4'd2, KIND_INVALID, 32'd0));
        send(mk(OP_QUERY, 4'd2, KIND_INVALID, 32'd0));
        send(mk(OP_QUERY, 4'd15, KIND_INVALID, 32'd0));
        send(mk(3'd6, 4'd1, KIND_ONESHOT, 32'd1));
        send(mk(3'd7, 4'd1, KIND_PERIODIC, 32'd1));
        send(mk(OP_REL_ALL, 4'd0, KIND_INVALID, 32'd0));
        send(mk(OP_REARM, 4'd0, KIND_INVALID, 32'd0));

        // random phases: none, sender idle, receiver stall, both
        for (ph = 0; ph < 4; ph++)
        begin
            sender_idles = (ph == 1) || (ph == 3);
            receiver_stalls = (ph == 2) || (ph == 3);
            if (ph == 0)
                hold_request = 1;
            repeat (RAND_ITEMS)
                send(random_cmd());
            cmd_valid <= 1'b0;
            wait_drained();
        end

        wait_drained();
        repeat (3 * NSLOT + 10) @(negedge clk);
        $display("%0d commands sent, %0d responses checked", cmds_sent, sb.checked);
        $display("%0d expired slots reported, %0d error responses", sb.fired_seen,
                 sb.err_seen);
        if (sb.mismatches == 0 && sb.pending_rsp.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
rtl/core/mstt_pkg.sv
rtl/core/mstt_adder.sv
rtl/core/multi_slot_timeout_table.sv
tb/testbench.sv
